// ----- rtl/fphdp_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package fphdp_pkg;

  // sizing
  localparam int MaxSites = 65536;
  localparam int SiteAw   = $clog2(MaxSites);
  localparam int CntW     = SiteAw + 1;

  // field widths
  localparam int PosW   = 30;
  localparam int UnitsW = 16;
  localparam int CostW  = 32;
  localparam int UPreW  = 33;
  localparam int WPreW  = 63;
  localparam int BestW  = 63;
  localparam int IcptW  = 66;

  // units times position of one site
  localparam int WIncW  = UnitsW + PosW;

  // shared multiplier: IcptW x UPreW, three digits of the wide operand
  localparam int MulAW     = IcptW;
  localparam int MulBW     = UPreW;
  localparam int MulPW     = MulAW + MulBW;
  localparam int MulDigits = 3;
  localparam int MulDigW   = MulAW / MulDigits;
  localparam int MulPpW    = MulDigW + MulBW;
  localparam int MulCntW   = 2;

  // comparison widths
  localparam int HeadW = IcptW + 1;
  localparam int CandW = IcptW + 2;
  localparam int TailW = MulPW - 1;

  localparam logic [BestW-1:0] Sat63 = {BestW{1'b1}};

  // one loaded site: position and cost of this site, prefix sums before it
  typedef struct packed {
    logic [PosW-1:0]  pos;
    logic [CostW-1:0] cost;
    logic [UPreW-1:0] u_pre;
    logic [WPreW-1:0] w_pre;
  } site_row_t;

  // one hull candidate: its position (slope) and intercept
  typedef struct packed {
    logic [PosW-1:0]  pos;
    logic [IcptW-1:0] icpt;
  } dq_ent_t;

  typedef enum logic [3:0] {
    S_LOAD,
    S_INIT_RD,
    S_CI_MS,
    S_CI_MW,
    S_TAIL_CHK,
    S_TAIL_B,
    S_TAIL_M1,
    S_TAIL_M2,
    S_TAIL_M3,
    S_HEAD_CHK,
    S_HEAD_RD,
    S_HEAD_M1,
    S_HEAD_M2,
    S_CAND_MS,
    S_CAND_MW
  } state_e;

endpackage

`default_nettype wire

// ----- rtl/facility_placement_hull_dp.sv -----
`timescale 1ns / 1ps
`default_nettype none

// channel  direction  handshake            payload
// in       sink       in_valid_i/in_stall_o position, units, build_cost, last_site
// out      source     out_valid_o/out_stall_i min_total_cost
//
// loading: one beat per cycle unless stalled; a last-marked beat starts the solve
// solve: the last site's row is read first, then each site is costed in turn,
// with tail and head tests once the deque holds two, and a pop for each drop;
// paced by the shared multiplier and the registered site and deque memories
// reset clears counters, sums and control only; the memories need no clearing
// a last-marked beat is stalled while a previous result still waits on out

module facility_placement_hull_dp (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic [fphdp_pkg::PosW-1:0]    in_position_i,
  input  wire logic [fphdp_pkg::UnitsW-1:0]  in_units_i,
  input  wire logic [fphdp_pkg::CostW-1:0]   in_build_cost_i,
  input  wire logic                          in_last_site_i,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic [fphdp_pkg::BestW-1:0]        out_min_total_cost_o
);

  fphdp_pkg::state_e state_q, state_d;

  logic [fphdp_pkg::CntW-1:0]   cnt_q, cnt_d, n_q, n_d, i_q, i_d, tail_q, tail_d;
  logic [fphdp_pkg::SiteAw-1:0] head_q, head_d;
  logic [fphdp_pkg::UPreW-1:0]  u_sum_q, u_sum_d;
  logic [fphdp_pkg::WPreW-1:0]  w_sum_q, w_sum_d;
  logic [fphdp_pkg::PosW-1:0]   prev_pos_q, prev_pos_d, posc_q, posc_d;
  logic [fphdp_pkg::BestW-1:0]  best_q, best_d, out_cost_q, out_cost_d;
  logic [fphdp_pkg::IcptW-1:0]  ic_q, ic_d;
  logic [fphdp_pkg::HeadW-1:0]  hl_q, hl_d;
  logic [fphdp_pkg::TailW-1:0]  tl_q, tl_d;
  logic                         out_valid_q, out_valid_d;

  // memories
  fphdp_pkg::site_row_t site_mem [fphdp_pkg::MaxSites];
  fphdp_pkg::site_row_t site_rd_q, site_wr_data;
  logic                         site_wr_en, site_rd_en;
  logic [fphdp_pkg::SiteAw-1:0] site_wr_addr, site_rd_addr;

  fphdp_pkg::dq_ent_t dq_mem [fphdp_pkg::MaxSites];
  fphdp_pkg::dq_ent_t dq_rd0_q, dq_rd1_q, dq_wr_data;
  logic                         dq_wr_en, dq_rd_en;
  logic [fphdp_pkg::SiteAw-1:0] dq_wr_addr, dq_rd_addr0, dq_rd_addr1;

  // multiplier
  logic [fphdp_pkg::MulAW-1:0]   mul_a_q, mul_a;
  logic [fphdp_pkg::MulBW-1:0]   mul_b_q, mul_b;
  logic [fphdp_pkg::MulPW-1:0]   mul_acc_q;
  logic [fphdp_pkg::MulPpW-1:0]  mul_pp;
  logic [fphdp_pkg::MulCntW-1:0] mul_cnt_q;
  logic                          mul_run_q, mul_start;

  logic                          in_fire, deep, head_drop, tail_drop, store;
  logic [fphdp_pkg::CntW-1:0]    dq_fill;
  logic [fphdp_pkg::PosW-1:0]    pos_eff, b1, b2;
  logic [fphdp_pkg::WIncW-1:0]   w_inc;
  logic [fphdp_pkg::UPreW-1:0]   x;
  logic [fphdp_pkg::HeadW-1:0]   head_r;
  logic [fphdp_pkg::CandW-1:0]   cand;
  logic [fphdp_pkg::IcptW-1:0]   icpt_new;
  logic [fphdp_pkg::BestW-1:0]   best_sat;

  // shared datapath terms
  assign in_stall_o = (state_q != fphdp_pkg::S_LOAD) || (in_last_site_i && out_valid_q);
  assign in_fire    = in_valid_i && !in_stall_o;
  assign store      = cnt_q < fphdp_pkg::CntW'(fphdp_pkg::MaxSites);
  assign pos_eff    = ((cnt_q != '0) && (in_position_i < prev_pos_q)) ? prev_pos_q
                                                                        : in_position_i;
  assign w_inc      = fphdp_pkg::WIncW'(in_units_i) * fphdp_pkg::WIncW'(pos_eff);
  assign dq_fill    = tail_q - {1'b0, head_q};
  assign deep       = dq_fill >= fphdp_pkg::CntW'(2);
  assign x          = site_rd_q.u_pre;
  assign b1         = dq_rd0_q.pos - dq_rd1_q.pos;
  assign b2         = dq_rd1_q.pos - posc_q;
  assign head_r     = {1'b0, dq_rd1_q.icpt} + fphdp_pkg::HeadW'(mul_acc_q[62:0]);
  assign head_drop  = head_r <= hl_q;
  assign tail_drop  = tl_q <= mul_acc_q[fphdp_pkg::TailW-1:0];
  assign cand       = fphdp_pkg::CandW'(dq_rd0_q.icpt) + fphdp_pkg::CandW'(site_rd_q.w_pre)
                    - fphdp_pkg::CandW'(mul_acc_q[62:0]);
  assign best_sat   = (cand[fphdp_pkg::CandW-1:fphdp_pkg::BestW] != '0) ? fphdp_pkg::Sat63
                                                                         : cand[62:0];
  assign icpt_new   = fphdp_pkg::IcptW'(best_q) + fphdp_pkg::IcptW'(site_rd_q.cost)
                    + mul_acc_q[fphdp_pkg::IcptW-1:0] - fphdp_pkg::IcptW'(site_rd_q.w_pre);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      fphdp_pkg::S_LOAD:     if (in_fire && in_last_site_i) state_d = fphdp_pkg::S_INIT_RD;
      fphdp_pkg::S_INIT_RD:  state_d = fphdp_pkg::S_CI_MS;
      fphdp_pkg::S_CI_MS:    state_d = fphdp_pkg::S_CI_MW;
      fphdp_pkg::S_CI_MW:    if (!mul_run_q) state_d = fphdp_pkg::S_TAIL_CHK;
      fphdp_pkg::S_TAIL_CHK: state_d = deep ? fphdp_pkg::S_TAIL_B : fphdp_pkg::S_HEAD_CHK;
      fphdp_pkg::S_TAIL_B:   state_d = fphdp_pkg::S_TAIL_M1;
      fphdp_pkg::S_TAIL_M1:  if (!mul_run_q) state_d = fphdp_pkg::S_TAIL_M2;
      fphdp_pkg::S_TAIL_M2:  if (!mul_run_q) state_d = fphdp_pkg::S_TAIL_M3;
      fphdp_pkg::S_TAIL_M3: begin
        if (!mul_run_q) state_d = tail_drop ? fphdp_pkg::S_TAIL_CHK : fphdp_pkg::S_HEAD_CHK;
      end
      fphdp_pkg::S_HEAD_CHK: state_d = deep ? fphdp_pkg::S_HEAD_RD : fphdp_pkg::S_CAND_MS;
      fphdp_pkg::S_HEAD_RD:  state_d = fphdp_pkg::S_HEAD_M1;
      fphdp_pkg::S_HEAD_M1:  if (!mul_run_q) state_d = fphdp_pkg::S_HEAD_M2;
      fphdp_pkg::S_HEAD_M2: begin
        if (!mul_run_q) state_d = head_drop ? fphdp_pkg::S_HEAD_CHK : fphdp_pkg::S_CAND_MS;
      end
      fphdp_pkg::S_CAND_MS:  state_d = fphdp_pkg::S_CAND_MW;
      fphdp_pkg::S_CAND_MW: begin
        if (!mul_run_q) state_d = (i_q == fphdp_pkg::CntW'(1)) ? fphdp_pkg::S_LOAD
                                                               : fphdp_pkg::S_CI_MS;
      end
      default: state_d = fphdp_pkg::S_LOAD;
    endcase
  end

  // outputs and datapath updates
  always_comb begin
    cnt_d        = cnt_q;
    n_d          = n_q;
    i_d          = i_q;
    tail_d       = tail_q;
    head_d       = head_q;
    u_sum_d      = u_sum_q;
    w_sum_d      = w_sum_q;
    prev_pos_d   = prev_pos_q;
    posc_d       = posc_q;
    best_d       = best_q;
    ic_d         = ic_q;
    hl_d         = hl_q;
    tl_d         = tl_q;
    out_valid_d  = out_valid_q && out_stall_i;
    out_cost_d   = out_cost_q;
    site_wr_en   = 1'b0;
    site_wr_addr = cnt_q[fphdp_pkg::SiteAw-1:0];
    site_wr_data = '{pos: pos_eff, cost: in_build_cost_i, u_pre: u_sum_q, w_pre: w_sum_q};
    site_rd_en   = 1'b0;
    site_rd_addr = '0;
    dq_wr_en     = 1'b0;
    dq_wr_addr   = tail_q[fphdp_pkg::SiteAw-1:0];
    dq_wr_data   = '{pos: posc_q, icpt: ic_q};
    dq_rd_en     = 1'b0;
    dq_rd_addr0  = head_q;
    dq_rd_addr1  = head_q + fphdp_pkg::SiteAw'(1);
    mul_start    = 1'b0;
    mul_a        = '0;
    mul_b        = '0;
    unique case (state_q)
      // load sites and keep running sums
      fphdp_pkg::S_LOAD: begin
        if (in_fire) begin
          if (store) begin
            site_wr_en = 1'b1;
            u_sum_d    = u_sum_q + fphdp_pkg::UPreW'(in_units_i);
            w_sum_d    = w_sum_q + fphdp_pkg::WPreW'(w_inc);
            prev_pos_d = pos_eff;
            cnt_d      = cnt_q + fphdp_pkg::CntW'(1);
          end
          if (in_last_site_i) begin
            n_d     = store ? cnt_q + fphdp_pkg::CntW'(1) : cnt_q;
            i_d     = n_d;
            cnt_d   = '0;
            u_sum_d = '0;
            w_sum_d = '0;
            head_d  = '0;
            tail_d  = '0;
            best_d  = '0;
          end
        end
      end
      // fetch the last site's row
      fphdp_pkg::S_INIT_RD: begin
        site_rd_en   = 1'b1;
        site_rd_addr = n_q[fphdp_pkg::SiteAw-1:0] - fphdp_pkg::SiteAw'(1);
      end
      // intercept of the new candidate
      fphdp_pkg::S_CI_MS: begin
        mul_start = 1'b1;
        mul_a     = fphdp_pkg::MulAW'(site_rd_q.pos);
        mul_b     = site_rd_q.u_pre;
      end
      fphdp_pkg::S_CI_MW: begin
        if (!mul_run_q) begin
          ic_d   = icpt_new;
          posc_d = site_rd_q.pos;
        end
      end
      // pop the tail or push the candidate
      fphdp_pkg::S_TAIL_CHK: begin
        if (deep) begin
          dq_rd_en    = 1'b1;
          dq_rd_addr0 = tail_q[fphdp_pkg::SiteAw-1:0] - fphdp_pkg::SiteAw'(2);
          dq_rd_addr1 = tail_q[fphdp_pkg::SiteAw-1:0] - fphdp_pkg::SiteAw'(1);
        end else begin
          dq_wr_en = 1'b1;
          tail_d   = tail_q + fphdp_pkg::CntW'(1);
        end
      end
      fphdp_pkg::S_TAIL_B: begin
        mul_start = 1'b1;
        mul_a     = dq_rd0_q.icpt;
        mul_b     = fphdp_pkg::MulBW'(b2);
      end
      fphdp_pkg::S_TAIL_M1: begin
        if (!mul_run_q) begin
          tl_d      = mul_acc_q[fphdp_pkg::TailW-1:0];
          mul_start = 1'b1;
          mul_a     = ic_q;
          mul_b     = fphdp_pkg::MulBW'(b1);
        end
      end
      fphdp_pkg::S_TAIL_M2: begin
        if (!mul_run_q) begin
          tl_d      = tl_q + mul_acc_q[fphdp_pkg::TailW-1:0];
          mul_start = 1'b1;
          mul_a     = dq_rd1_q.icpt;
          mul_b     = fphdp_pkg::MulBW'(b1) + fphdp_pkg::MulBW'(b2);
        end
      end
      fphdp_pkg::S_TAIL_M3: begin
        if (!mul_run_q) begin
          if (tail_drop) begin
            tail_d = tail_q - fphdp_pkg::CntW'(1);
          end else begin
            dq_wr_en = 1'b1;
            tail_d   = tail_q + fphdp_pkg::CntW'(1);
          end
        end
      end
      // head check for the query of site i
      fphdp_pkg::S_HEAD_CHK: begin
        dq_rd_en = 1'b1;
      end
      fphdp_pkg::S_HEAD_RD: begin
        mul_start = 1'b1;
        mul_a     = fphdp_pkg::MulAW'(dq_rd1_q.pos);
        mul_b     = x;
      end
      fphdp_pkg::S_HEAD_M1: begin
        if (!mul_run_q) begin
          hl_d      = {1'b0, dq_rd0_q.icpt} + fphdp_pkg::HeadW'(mul_acc_q[62:0]);
          mul_start = 1'b1;
          mul_a     = fphdp_pkg::MulAW'(dq_rd0_q.pos);
          mul_b     = x;
        end
      end
      fphdp_pkg::S_HEAD_M2: begin
        if (!mul_run_q && head_drop) head_d = head_q + fphdp_pkg::SiteAw'(1);
      end
      // best cost of site i from the head candidate
      fphdp_pkg::S_CAND_MS: begin
        mul_start = 1'b1;
        mul_a     = fphdp_pkg::MulAW'(dq_rd0_q.pos);
        mul_b     = x;
      end
      fphdp_pkg::S_CAND_MW: begin
        if (!mul_run_q) begin
          best_d = best_sat;
          if (i_q == fphdp_pkg::CntW'(1)) begin
            out_valid_d = 1'b1;
            out_cost_d  = best_sat;
          end else begin
            i_d          = i_q - fphdp_pkg::CntW'(1);
            site_rd_en   = 1'b1;
            site_rd_addr = i_q[fphdp_pkg::SiteAw-1:0] - fphdp_pkg::SiteAw'(2);
          end
        end
      end
      default: begin
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= fphdp_pkg::S_LOAD;
      cnt_q       <= '0;
      n_q         <= '0;
      i_q         <= '0;
      head_q      <= '0;
      tail_q      <= '0;
      u_sum_q     <= '0;
      w_sum_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      n_q         <= n_d;
      i_q         <= i_d;
      head_q      <= head_d;
      tail_q      <= tail_d;
      u_sum_q     <= u_sum_d;
      w_sum_q     <= w_sum_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    prev_pos_q <= prev_pos_d;
    posc_q     <= posc_d;
    best_q     <= best_d;
    ic_q       <= ic_d;
    hl_q       <= hl_d;
    tl_q       <= tl_d;
    out_cost_q <= out_cost_d;
  end

  // shared multiplier, most significant digit first
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mul_run_q <= 1'b0;
      mul_cnt_q <= '0;
    end else if (mul_start) begin
      mul_run_q <= 1'b1;
      mul_cnt_q <= '0;
    end else if (mul_run_q) begin
      mul_cnt_q <= mul_cnt_q + fphdp_pkg::MulCntW'(1);
      if (mul_cnt_q == fphdp_pkg::MulCntW'(fphdp_pkg::MulDigits - 1)) mul_run_q <= 1'b0;
    end
  end

  // one digit times the narrow operand
  assign mul_pp = fphdp_pkg::MulPpW'(mul_a_q[fphdp_pkg::MulAW-1 -: fphdp_pkg::MulDigW])
                * fphdp_pkg::MulPpW'(mul_b_q);

  always_ff @(posedge clk_i) begin
    if (mul_start) begin
      mul_a_q   <= mul_a;
      mul_b_q   <= mul_b;
      mul_acc_q <= '0;
    end else if (mul_run_q) begin
      mul_a_q   <= mul_a_q << fphdp_pkg::MulDigW;
      mul_acc_q <= (mul_acc_q << fphdp_pkg::MulDigW) + fphdp_pkg::MulPW'(mul_pp);
    end
  end

  // site memory
  always_ff @(posedge clk_i) begin
    if (site_wr_en) site_mem[site_wr_addr] <= site_wr_data;
    if (site_rd_en) site_rd_q <= site_mem[site_rd_addr];
  end

  // deque memory, two read ports
  always_ff @(posedge clk_i) begin
    if (dq_wr_en) dq_mem[dq_wr_addr] <= dq_wr_data;
    if (dq_rd_en) begin
      dq_rd0_q <= dq_mem[dq_rd_addr0];
      dq_rd1_q <= dq_mem[dq_rd_addr1];
    end
  end

  assign out_valid_o          = out_valid_q;
  assign out_min_total_cost_o = out_cost_q;

endmodule

`default_nettype wire

// ----- tb/tb_facility_placement_hull_dp.sv -----
`timescale 1ns / 1ps

module tb_facility_placement_hull_dp;

  localparam int PosW     = fphdp_pkg::PosW;
  localparam int UnitsW   = fphdp_pkg::UnitsW;
  localparam int CostW    = fphdp_pkg::CostW;
  localparam int BestW    = fphdp_pkg::BestW;
  localparam int MaxSites = fphdp_pkg::MaxSites;
  localparam logic [BestW-1:0] Sat63 = fphdp_pkg::Sat63;

  localparam int PosMax = (1 << PosW) - 1;
  localparam int StallLimit = 40000;
  localparam int LongHold = 3000;

  typedef struct {
    logic [PosW-1:0]   pos;
    logic [UnitsW-1:0] units;
    logic [CostW-1:0]  cost;
    logic              last;
    logic              drain_first;
  } site_beat_t;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  logic [PosW-1:0] in_position;
  logic [UnitsW-1:0] in_units;
  logic [CostW-1:0] in_build_cost;
  logic in_last_site;
  logic out_valid;
  logic out_stall;
  logic [BestW-1:0] out_min_total_cost;

  site_beat_t site_q[$];
  logic [BestW-1:0] cost_q[$];
  int err_cnt;
  int results_seen;
  int quiet_cycles;
  bit calm;

  // predictor state
  logic [PosW-1:0]  p_pos[MaxSites + 2];
  logic [CostW-1:0] p_cost[MaxSites + 2];
  logic [63:0]      p_upre[MaxSites + 2];
  logic [127:0]     p_wpre[MaxSites + 2];
  logic [63:0]      p_best[MaxSites + 2];
  int               p_hull[MaxSites + 2];
  int               p_count;

  facility_placement_hull_dp dut (
    .clk_i               (clk),
    .rst_ni              (rst_n),
    .in_valid_i          (in_valid),
    .in_stall_o          (in_stall),
    .in_position_i       (in_position),
    .in_units_i          (in_units),
    .in_build_cost_i     (in_build_cost),
    .in_last_site_i      (in_last_site),
    .out_valid_o         (out_valid),
    .out_stall_i         (out_stall),
    .out_min_total_cost_o(out_min_total_cost)
  );

  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  // line intercept of candidate depot k
  function automatic logic [127:0] depot_icpt(int k);
    return 128'(p_best[k+1]) + 128'(p_cost[k]) + 128'(p_pos[k]) * 128'(p_upre[k-1])
           - p_wpre[k-1];
  endfunction

  function automatic bit head_worse(int k1, int k2, logic [63:0] x);
    logic [127:0] l;
    logic [127:0] r;
    l = depot_icpt(k1) + 128'(p_pos[k2]) * 128'(x);
    r = depot_icpt(k2) + 128'(p_pos[k1]) * 128'(x);
    return r <= l;
  endfunction

  function automatic bit mid_useless(int a, int b, int c);
    logic [63:0] d1;
    logic [63:0] d2;
    logic [127:0] l;
    logic [127:0] r;
    d1 = 64'(p_pos[a]) - 64'(p_pos[b]);
    d2 = 64'(p_pos[b]) - 64'(p_pos[c]);
    l = depot_icpt(a) * 128'(d2) + depot_icpt(c) * 128'(d1);
    r = depot_icpt(b) * 128'(d1 + d2);
    return l <= r;
  endfunction

  // backward dp over the loaded batch with a monotone hull
  function automatic logic [BestW-1:0] least_cost(int n);
    int hd;
    int tl;
    int k;
    logic [63:0] x;
    logic [127:0] cand;
    p_best[n+1] = '0;
    hd = 0;
    tl = 1;
    p_hull[0] = n;
    for (int i = n; i >= 1; i--) begin
      x = p_upre[i-1];
      while (tl - hd >= 2 && head_worse(p_hull[hd], p_hull[hd+1], x)) hd++;
      k = p_hull[hd];
      cand = depot_icpt(k) + p_wpre[i-1] - 128'(p_pos[k]) * 128'(x);
      p_best[i] = (cand > 128'(Sat63)) ? 64'(Sat63) : cand[63:0];
      if (i > 1) begin
        while (tl - hd >= 2 && mid_useless(p_hull[tl-2], p_hull[tl-1], i - 1)) tl--;
        p_hull[tl] = i - 1;
        tl++;
      end
    end
    return p_best[1][BestW-1:0];
  endfunction

  // load one accepted beat, queue the batch cost on a last beat
  function automatic void load_site(site_beat_t b);
    int j;
    logic [PosW-1:0] ps;
    if (p_count < MaxSites) begin
      j = p_count + 1;
      ps = b.pos;
      if (p_count > 0 && ps < p_pos[p_count]) ps = p_pos[p_count];
      p_pos[j] = ps;
      p_cost[j] = b.cost;
      p_upre[j] = p_upre[j-1] + 64'(b.units);
      p_wpre[j] = p_wpre[j-1] + 128'(b.units) * 128'(ps);
      p_count = j;
    end
    if (b.last) begin
      cost_q.push_back(least_cost(p_count));
      p_count = 0;
    end
  endfunction

  // sender: one beat per handshake, idle bursts, optional drain before a beat
  always @(posedge clk or negedge rst_n) begin
    bit v;
    int idle_left;
    site_beat_t b;
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_position <= '0;
      in_units <= '0;
      in_build_cost <= '0;
      in_last_site <= 1'b0;
      idle_left = 0;
    end else begin
      v = in_valid;
      if (in_valid && !in_stall) begin
        load_site(site_q.pop_front());
        v = 1'b0;
      end
      calm = (site_q.size() < 120);
      if (!v) begin
        if (idle_left > 0) begin
          idle_left--;
        end else if (site_q.size() > 0) begin
          if (!calm && $urandom_range(0, 9) == 0) begin
            idle_left = int'($urandom_range(1, 12)) - 1;
          end else if (!site_q[0].drain_first || cost_q.size() == 0) begin
            b = site_q[0];
            site_q[0].drain_first = 1'b0;
            in_position <= b.pos;
            in_units <= b.units;
            in_build_cost <= b.cost;
            in_last_site <= b.last;
            v = 1'b1;
          end
        end
      end
      in_valid <= v;
    end
  end

  // receiver: random stall bursts and one long hold-off
  always @(posedge clk or negedge rst_n) begin
    int hold_left;
    bit long_done;
    if (!rst_n) begin
      out_stall <= 1'b0;
      hold_left = 0;
      long_done = 1'b0;
    end else begin
      if (!long_done && results_seen == 15) begin
        long_done = 1'b1;
        hold_left = LongHold;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (!calm && $urandom_range(0, 9) == 0) begin
        hold_left = int'($urandom_range(1, 12)) - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // result check and watchdog
  always @(posedge clk) begin
    logic [BestW-1:0] want;
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
      if (out_valid && !out_stall) begin
        results_seen <= results_seen + 1;
        if (cost_q.size() == 0) begin
          $error("unexpected result min_total_cost=%0d", out_min_total_cost);
          err_cnt++;
        end else begin
          want = cost_q.pop_front();
          if (out_min_total_cost !== want) begin
            $error("min_total_cost expected %0d actual %0d", want, out_min_total_cost);
            err_cnt++;
          end
        end
      end
      if (quiet_cycles >= StallLimit) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  task automatic add_site(int ps, int u, longint c, bit lst, bit drain);
    site_beat_t b;
    b.pos = PosW'(ps);
    b.units = UnitsW'(u);
    b.cost = CostW'(c);
    b.last = lst;
    b.drain_first = drain;
    site_q.push_back(b);
  endtask

  // one batch with random content; a few positions step back as noise
  task automatic add_batch(int n, bit drain);
    longint ps;
    int u;
    longint c;
    ps = (n > 20) ? longint'($urandom_range(0, 1 << 20))
                  : longint'($urandom_range(0, PosMax));
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 3))
        0: u = 0;
        1: u = 65535;
        default: u = int'($urandom_range(0, 65535));
      endcase
      case ($urandom_range(0, 4))
        0: c = 0;
        1: c = 64'hFFFF_FFFF;
        2: c = longint'($urandom_range(0, 1000));
        default: c = longint'($urandom);
      endcase
      add_site(int'(ps), u, c, i == n - 1, drain && i == 0);
      case ($urandom_range(0, 15))
        0: ps = ps - longint'($urandom_range(0, 1000));
        1, 2, 3: ps = ps + longint'($urandom_range(1, 1 << 24));
        default: ps = ps + longint'($urandom_range(1, 64));
      endcase
      if (ps < 0) ps = 0;
      if (ps > PosMax) ps = PosMax;
    end
  endtask

  initial begin
    int n_items;
    int n;
    err_cnt = 0;
    results_seen = 0;
    quiet_cycles = 0;
    calm = 0;
    p_count = 0;
    p_upre[0] = '0;
    p_wpre[0] = '0;
    rst_n = 1'b0;

    // directed: single site, extremes, flat and backward positions
    add_site(PosMax, '1, '1, 1'b1, 1'b0);
    add_site('0, '0, '0, 1'b1, 1'b0);
    add_site('0, '1, '1, 1'b0, 1'b0);
    add_site(PosMax / 2, '1, '1, 1'b0, 1'b0);
    add_site(PosMax, '1, '1, 1'b1, 1'b0);
    add_site(100, 5, 10, 1'b0, 1'b0);
    add_site(100, 7, 20, 1'b0, 1'b0);
    add_site(50, 9, '1, 1'b0, 1'b0);
    add_site(300, 3, 0, 1'b1, 1'b0);
    add_site(10, 1000, '1, 1'b0, 1'b1);
    add_site(20, 1000, '1, 1'b0, 1'b0);
    add_site(30, 1000, '1, 1'b0, 1'b0);
    add_site(40, 0, 0, 1'b1, 1'b0);
    add_site(1, '0, 0, 1'b0, 1'b0);
    add_site(PosMax - 1, '1, 0, 1'b0, 1'b0);
    add_site(PosMax, 0, 0, 1'b1, 1'b0);
    n_items = site_q.size();

    // random batches, mostly short
    while (n_items < 950) begin
      n = ($urandom_range(0, 19) == 0) ? int'($urandom_range(30, 64))
                                        : int'($urandom_range(1, 12));
      add_batch(n, $urandom_range(0, 14) == 0);
      n_items += n;
    end

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    wait (site_q.size() == 0 && !in_valid && cost_q.size() == 0);
    repeat (200) @(posedge clk);
    if (err_cnt == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
